/* sv/lfrs_pkg.sv */
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants for the line-follow ring sequencer.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  typedef enum logic [2:0] {
    EL_NORMAL      = 3'd0,
    EL_RIGHT_CUT   = 3'd1,
    EL_LEFT_CUT    = 3'd2,
    EL_RIGHT_TRACE = 3'd3,
    EL_LEFT_TRACE  = 3'd4,
    EL_STOPPED     = 3'd5
  } element_t;

  typedef enum logic [1:0] {
    SRC_LINE = 2'd0,
    SRC_GYRO = 2'd1,
    SRC_STOP = 2'd2
  } source_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_RING, ST_OUT
  } state_t;

  localparam logic [2:0] ADDR_RING_MODE   = 3'd0;
  localparam logic [2:0] ADDR_CENTER_THR  = 3'd1;
  localparam logic [2:0] ADDR_SIDE_THR    = 3'd2;
  localparam logic [2:0] ADDR_ENTER_CUT   = 3'd3;
  localparam logic [2:0] ADDR_ENTER_TRACE = 3'd4;
  localparam logic [2:0] ADDR_ERROR_GAIN  = 3'd5;
  localparam logic [2:0] ADDR_CENTER_WT   = 3'd6;

  // quotient bits produced by the restoring divider
  localparam int QBITS = 20;
  // dividend width: |gain*num|*512 + divisor
  localparam int NUMW  = 37;
  // divisor width before doubling
  localparam int DENW  = 24;
  // partial remainder width, holds up to twice the divisor
  localparam int PARTW = DENW + 1;
  localparam int REMW  = PARTW + QBITS;

endpackage

/* sv/line_follow_ring_sequencer_core.sv */
// ----------------------------------------------------------------------------
// line_follow_ring_sequencer_core
// Steering error and roundabout sequencer for a five-coil track sensor.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to a valid result in these steps: the
// PREP state forms numerator and divisor, the first DIV state loads the
// dividend, then one shared restoring subtract-and-shift unit produces the
// 20 quotient bits of the error, one bit per cycle, and the RING state
// updates the roundabout state. The block takes one request at a time;
// stall stays high while it works or holds a result, so a new request is
// accepted only after the previous result has been taken.
module line_follow_ring_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         sense_left,
  input  logic [7:0]         sense_left_mid,
  input  logic [7:0]         sense_center,
  input  logic [7:0]         sense_right_mid,
  input  logic [7:0]         sense_right,
  input  logic signed [11:0] wheel_speed,
  input  logic signed [11:0] heading_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] steer_error,
  output logic [2:0]         element_code,
  output logic [2:0]         ring_phase,
  output logic [1:0]         steer_source,
  output logic signed [10:0] gyro_target,
  output logic [9:0]         speed_setpoint,
  output logic               heading_clear,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lfrs_pkg::*;

  // configuration
  logic        ring_mode;
  logic [7:0]  center_thr, side_thr, error_gain;
  logic [14:0] enter_cut, enter_trace;
  logic [4:0]  center_wt;

  // architectural state
  element_t    element_reg;
  logic [2:0]  phase_reg;
  logic [31:0] distance_acc;
  logic [7:0]  holdoff_count;

  // captured request
  logic [7:0]  l_q, lm_q, m_q, rm_q, r_q;
  logic signed [11:0] spd_q, head_q;

  state_t      state, state_next;
  logic [4:0]  bit_cnt;
  logic [REMW-1:0] rem;      // partial remainder above, dividend / quotient below
  logic [DENW-1:0] den;
  logic [25:0] num_a;        // |1000*(R-L) + 20*w*d| before gain
  logic        num_neg;

  wire cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_mode <= 1'b1; center_thr <= 8'd80; side_thr <= 8'd55;
      enter_cut <= 15'd2300; enter_trace <= 15'd4000;
      error_gain <= 8'd45; center_wt <= 5'd7;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        ADDR_RING_MODE:   ring_mode   <= pwdata[0];
        ADDR_CENTER_THR:  center_thr  <= pwdata[7:0];
        ADDR_SIDE_THR:    side_thr    <= pwdata[7:0];
        ADDR_ENTER_CUT:   enter_cut   <= pwdata[14:0];
        ADDR_ENTER_TRACE: enter_trace <= pwdata[14:0];
        ADDR_ERROR_GAIN:  error_gain  <= pwdata[7:0];
        ADDR_CENTER_WT:   center_wt   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ADDR_RING_MODE:   prdata = {31'd0, ring_mode};
      ADDR_CENTER_THR:  prdata = {24'd0, center_thr};
      ADDR_SIDE_THR:    prdata = {24'd0, side_thr};
      ADDR_ENTER_CUT:   prdata = {17'd0, enter_cut};
      ADDR_ENTER_TRACE: prdata = {17'd0, enter_trace};
      ADDR_ERROR_GAIN:  prdata = {24'd0, error_gain};
      ADDR_CENTER_WT:   prdata = {27'd0, center_wt};
      default:          prdata = 32'd0;
    endcase
  end

  // ---- setup arithmetic (cycle PREP) ----
  logic [5:0]  w;
  logic signed [8:0] d;
  logic [7:0]  ad;
  logic signed [26:0] num_raw;
  logic [DENW-1:0] den_raw;
  always_comb begin
    if (m_q >= 8'd60)      w = 6'd10;
    else if (m_q <= 8'd30) w = 6'd40;
    else                   w = 6'(7'd70 - {1'b0, m_q[5:0]});
    d  = $signed({1'b0, rm_q}) - $signed({1'b0, lm_q});
    ad = d[8] ? 8'(-d) : d[7:0];
    num_raw = 27'sd1000 * ($signed({1'b0, r_q}) - $signed({1'b0, l_q}))
            + $signed({1'b0, 11'(w) * 11'd20}) * 27'(d);
    den_raw = DENW'(10'(l_q) + 10'(r_q)) * 24'd1000
            + DENW'(13'(m_q) * 13'(center_wt)) * 24'd1000
            + DENW'(15'(w) * 15'(ad) * 15'd3);
  end

  // ---- next-state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (bit_cnt == 5'd0) state_next = ST_RING;
      ST_RING: state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  // divider step: dividend = |gain*num|*512 + den, divisor 2*den
  logic [26:0]      prod;
  logic [NUMW-1:0]  dividend;
  logic [PARTW-1:0] den2, part_n;
  logic [PARTW:0]   shifted;
  logic             sub_ok;
  always_comb begin
    prod     = 27'(num_a) * 27'(error_gain);
    dividend = NUMW'({prod, 9'd0}) + NUMW'(den);
    den2     = {den, 1'b0};
    shifted  = {rem[REMW-1:QBITS], rem[QBITS-1]};
    sub_ok   = shifted >= {1'b0, den2};
    part_n   = sub_ok ? PARTW'(shifted - {1'b0, den2}) : shifted[PARTW-1:0];
  end

  // ring decisions
  logic right, trace, det_r, det_l, lost;
  logic signed [12:0] h;
  logic [31:0] dist_sum;
  element_t el;
  always_comb begin
    det_r = (m_q > center_thr) && (r_q > side_thr) && (holdoff_count == 8'd0);
    det_l = (m_q > center_thr) && (l_q > side_thr) && (holdoff_count == 8'd0);
    lost  = (10'(l_q) + 10'(lm_q) + 10'(rm_q) + 10'(r_q)) < 10'd20;
    el = element_reg;
    if (det_r) el = ring_mode ? EL_LEFT_CUT : EL_LEFT_TRACE;
    if (det_l) el = ring_mode ? EL_RIGHT_CUT : EL_RIGHT_TRACE;
    if (lost)  el = EL_STOPPED;
    right = (el == EL_RIGHT_CUT) || (el == EL_RIGHT_TRACE);
    trace = (el == EL_RIGHT_TRACE) || (el == EL_LEFT_TRACE);
    h = right ? 13'(head_q) : -13'(head_q);
    dist_sum = distance_acc + 32'(spd_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      element_reg <= EL_NORMAL; phase_reg <= 3'd1;
      distance_acc <= '0; holdoff_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RING) begin
        element_reg <= el;
        if (el == EL_NORMAL) begin
          if (holdoff_count != 8'd0) holdoff_count <= holdoff_count - 8'd1;
        end else if (el != EL_STOPPED) begin
          unique case (phase_reg)
            3'd1: begin
              holdoff_count <= 8'd200;
              distance_acc  <= dist_sum;
              if ($signed(dist_sum) > $signed({17'd0, trace ? enter_trace : enter_cut})) begin
                distance_acc <= '0; phase_reg <= 3'd2;
              end
            end
            3'd2: if (h > (trace ? 13'sd40 : 13'sd50)) phase_reg <= 3'd3;
            3'd3: if (h > 13'sd260) phase_reg <= 3'd4;
            3'd4: if (h > (trace ? 13'sd330 : 13'sd340)) phase_reg <= 3'd5;
            3'd5: begin
              distance_acc <= dist_sum;
              if ($signed(dist_sum) > 32'sd5000) begin
                distance_acc <= '0; phase_reg <= 3'd1; element_reg <= EL_NORMAL;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      l_q <= sense_left; lm_q <= sense_left_mid; m_q <= sense_center;
      rm_q <= sense_right_mid; r_q <= sense_right;
      spd_q <= wheel_speed; head_q <= heading_deg;
    end
    if (state == ST_PREP) begin
      num_a   <= num_raw[26] ? 26'(-num_raw) : 26'(num_raw);
      num_neg <= num_raw[26];
      den     <= (den_raw < 24'd250000) ? 24'd250000 : den_raw;
      bit_cnt <= 5'(QBITS);
    end
    if (state == ST_DIV) begin
      if (bit_cnt == 5'(QBITS)) begin
        // load: high dividend bits start as the partial remainder
        rem <= {PARTW'(dividend[NUMW-1:QBITS]), dividend[QBITS-1:0]};
      end else begin
        rem <= {part_n, rem[QBITS-2:0], sub_ok};
      end
      bit_cnt <= bit_cnt - 5'd1;
    end
  end

  // result formatting
  logic signed [15:0] err_sat;
  logic [QBITS-1:0] qmag;
  always_comb begin
    qmag = rem[QBITS-1:0];
    if (qmag > QBITS'(32767)) err_sat = num_neg ? -16'sd32768 : 16'sd32767;
    else err_sat = num_neg ? -$signed({1'b0, qmag[14:0]}) : $signed({1'b0, qmag[14:0]});
  end

  logic clr_q;
  logic ring_is_right, ring_is_trace;
  always_ff @(posedge clk) begin
    if (state == ST_RING) begin
      clr_q <= (el != EL_NORMAL) && (el != EL_STOPPED) &&
               (((phase_reg == 3'd1) &&
                 ($signed(dist_sum) > $signed({17'd0, trace ? enter_trace : enter_cut}))) ||
                ((phase_reg == 3'd5) && ($signed(dist_sum) > 32'sd5000)));
      steer_error   <= err_sat;
      ring_is_right <= right;
      ring_is_trace <= trace;
    end
  end

  always_comb begin
    element_code   = element_reg;
    ring_phase     = phase_reg;
    heading_clear  = clr_q;
    steer_source   = SRC_LINE;
    gyro_target    = '0;
    speed_setpoint = 10'd195;
    if (element_reg == EL_STOPPED) begin
      steer_source = SRC_STOP; speed_setpoint = 10'd0;
    end else if (element_reg != EL_NORMAL || clr_q) begin
      // ring element, or the exit tick that reports normal with phase 1 action
      steer_source = SRC_GYRO; speed_setpoint = 10'd190;
      unique case (phase_reg)
        3'd2: gyro_target = ring_is_trace ? 11'sd600 : 11'sd550;
        3'd3: if (ring_is_trace) steer_source = SRC_LINE; else gyro_target = 11'sd750;
        3'd4: gyro_target = ring_is_trace ? 11'sd650 : 11'sd500;
        3'd5: speed_setpoint = 10'd195;
        default: ;
      endcase
      if (!ring_is_right) gyro_target = -gyro_target;
    end
  end
endmodule

/* tb/sv/tb_line_follow_ring_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_line_follow_ring_sequencer_core
// Self-checking bench: drives sensor requests with random idling on both sides,
// predicts each result in a scoreboard and compares every output field.
// ----------------------------------------------------------------------------
module tb_line_follow_ring_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lfrs_pkg::*;

  typedef struct packed {
    logic [7:0]         l, lm, m, rm, r;
    logic signed [11:0] spd, head;
  } sense_req_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic [2:0]         elem, phase;
    logic [1:0]         src;
    logic signed [10:0] gyro;
    logic [9:0]         speed;
    logic               clr;
  } steer_res_t;

  class ring_scoreboard;
    bit [0:0]  mode;
    bit [7:0]  center_thr, side_thr, gain;
    bit [14:0] enter_cut, enter_trace;
    bit [4:0]  center_wt;
    bit [2:0]  elem, phase;
    bit [31:0] travel;
    bit [7:0]  holdoff;
    steer_res_t pending[$];
    int errors;

    function new();
      mode = 1; center_thr = 80; side_thr = 55; enter_cut = 2300;
      enter_trace = 4000; gain = 45; center_wt = 7;
      elem = EL_NORMAL; phase = 1; travel = 0; holdoff = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] a, logic [31:0] v);
      case (a)
        ADDR_RING_MODE:   mode = v[0];
        ADDR_CENTER_THR:  center_thr = v[7:0];
        ADDR_SIDE_THR:    side_thr = v[7:0];
        ADDR_ENTER_CUT:   enter_cut = v[14:0];
        ADDR_ENTER_TRACE: enter_trace = v[14:0];
        ADDR_ERROR_GAIN:  gain = v[7:0];
        ADDR_CENTER_WT:   center_wt = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(sense_req_t q);
      longint w, d, ad, num, den, mag, e, enter;
      int h, gy, lv, lmv, mv, rmv, rv;
      bit right, trace;
      steer_res_t o;
      lv = q.l; lmv = q.lm; mv = q.m; rmv = q.rm; rv = q.r;
      w = 70 - mv;
      if (w < 10) w = 10;
      if (w > 40) w = 40;
      d = rmv - lmv;
      ad = d < 0 ? -d : d;
      num = longint'(gain) * (1000 * (rv - lv) + 20 * w * d);
      den = 1000 * (lv + rv) + 1000 * longint'(center_wt) * mv + 3 * w * ad;
      if (den < 250000) den = 250000;
      mag = num < 0 ? -num : num;
      mag = (mag * 512 + den) / (2 * den);
      e = num < 0 ? -mag : mag;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      o = '0;
      o.err = e[15:0]; o.speed = 195; gy = 0;
      if (mv > center_thr && rv > side_thr && holdoff == 0)
        elem = mode ? EL_LEFT_CUT : EL_LEFT_TRACE;
      if (mv > center_thr && lv > side_thr && holdoff == 0)
        elem = mode ? EL_RIGHT_CUT : EL_RIGHT_TRACE;
      if (lv + lmv + rmv + rv < 20) elem = EL_STOPPED;
      if (elem == EL_NORMAL) begin
        if (holdoff > 0) holdoff--;
      end else if (elem == EL_STOPPED) begin
        o.src = SRC_STOP; o.speed = 0;
      end else begin
        right = (elem == EL_RIGHT_CUT || elem == EL_RIGHT_TRACE);
        trace = (elem >= EL_RIGHT_TRACE);
        h = right ? int'(q.head) : -int'(q.head);
        enter = trace ? longint'(enter_trace) : longint'(enter_cut);
        case (phase)
          1: begin
            holdoff = 200;
            travel = travel + 32'(int'(q.spd));
            if (longint'($signed(travel)) > enter) begin
              travel = 0; phase = 2; o.clr = 1;
            end
          end
          2: if (h > (trace ? 40 : 50)) phase = 3;
          3: if (h > 260) phase = 4;
          4: if (h > (trace ? 330 : 340)) phase = 5;
          5: begin
            travel = travel + 32'(int'(q.spd));
            if ($signed(travel) > 5000) begin
              travel = 0; phase = 1; elem = EL_NORMAL; o.clr = 1;
            end
          end
          default: ;
        endcase
        o.speed = 190; o.src = SRC_GYRO;
        case (phase)
          2: gy = trace ? 600 : 550;
          3: if (trace) o.src = SRC_LINE; else gy = 750;
          4: gy = trace ? 650 : 500;
          5: o.speed = 195;
          default: ;
        endcase
        if (!right) gy = -gy;
      end
      o.gyro = gy[10:0]; o.elem = elem; o.phase = phase;
      pending.push_back(o);
    endfunction

    function void check_result(steer_res_t a);
      steer_res_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", a);
        return;
      end
      x = pending.pop_front();
      if (a !== x) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", x, a);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [7:0] sense_left = 0, sense_left_mid = 0, sense_center = 0;
  logic [7:0] sense_right_mid = 0, sense_right = 0;
  logic signed [11:0] wheel_speed = 0, heading_deg = 0;
  logic in_stall, out_valid, heading_clear, pready;
  logic signed [15:0] steer_error;
  logic [2:0] element_code, ring_phase;
  logic [1:0] steer_source;
  logic signed [10:0] gyro_target;
  logic [9:0] speed_setpoint;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  ring_scoreboard sb = new();
  int send_idle = 34, recv_idle = 63;
  longint cycles = 0;

  always #6 clk = ~clk;

  line_follow_ring_sequencer_core dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: sample at the edge, then choose next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result({steer_error, element_code, ring_phase, steer_source,
                         gyro_target, speed_setpoint, heading_clear});
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic cfg_write(logic [2:0] a, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {a, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(a, v);
  endtask

  // valid stays high after an accept when the next request follows at once
  task automatic send(sense_req_t q);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {sense_left, sense_left_mid, sense_center, sense_right_mid, sense_right,
     wheel_speed, heading_deg} <= q;
    do @(posedge clk); while (in_stall);
    sb.note_request(q);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic sense_req_t rand_req();
    sense_req_t q;
    q.l = 8'($urandom); q.lm = 8'($urandom); q.m = 8'($urandom);
    q.rm = 8'($urandom); q.r = 8'($urandom);
    q.spd = 12'($urandom); q.head = 12'($urandom);
    if ($urandom_range(3) == 0) begin
      q.l = 8'($urandom_range(5)); q.lm = 8'($urandom_range(5));
      q.rm = 8'($urandom_range(5)); q.r = 8'($urandom_range(4));
    end
    return q;
  endfunction

  // full roundabout with random content: detect, drive in, sweep heading
  task automatic ring_run(bit left);
    sense_req_t q;
    int hd, sg;
    sg = left ? -1 : 1;
    q = rand_req();
    q.m = 8'(200 + $urandom_range(55));
    if (left) begin q.r = 255; q.l = 8'($urandom_range(40)); end
    else q.l = 8'(250 + $urandom_range(5));
    q.lm = 100; q.spd = 12'(800 + $urandom_range(1247));
    send(q);
    repeat ($urandom_range(8, 3)) begin
      q = rand_req(); q.l = 100; q.m = 40; q.spd = 12'(1000 + $urandom_range(1047));
      send(q);
    end
    hd = 0;
    repeat ($urandom_range(40, 15)) begin
      q = rand_req(); q.l = 8'(90 + $urandom_range(100)); q.m = 8'($urandom_range(60));
      hd += $urandom_range(40);
      q.head = 12'(sg * hd); q.spd = 12'($urandom_range(1500));
      send(q);
    end
  endtask

  initial begin
    sense_req_t q;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed extremes
    q = '0; send(q);
    q = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 12'sh7ff, 12'sh7ff}; send(q);
    q = {8'hff, 8'h00, 8'h00, 8'hff, 8'h00, -12'sd2048, -12'sd2048}; send(q);
    q = {8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 12'sd5, 12'sd0}; send(q);
    q = {8'd5, 8'd5, 8'd0, 8'd5, 8'd4, 12'sd1, 12'sd1}; send(q);
    q = {8'd5, 8'd5, 8'd0, 8'd5, 8'd5, 12'sd1, 12'sd1}; send(q);
    q = {8'd0, 8'd0, 8'd81, 8'd0, 8'd56, 12'sd2047, 12'sd0}; send(q);
    q = {8'd56, 8'd0, 8'd81, 8'd0, 8'd56, 12'sd2047, 12'sd0}; send(q);
    drain();
    ring_run(0); ring_run(1);
    drain();
    cfg_write(ADDR_RING_MODE, 0);
    cfg_write(ADDR_ENTER_TRACE, 0);
    cfg_write(ADDR_CENTER_WT, 31);
    cfg_write(ADDR_ERROR_GAIN, 255);
    ring_run(0); ring_run(1);
    for (int i = 0; i < 250; i++) begin
      if (i % 50 == 0) ring_run(i % 100 == 0); else send(rand_req());
    end
    drain();
    send_idle = 63; recv_idle = 34;
    cfg_write(ADDR_CENTER_THR, 0);
    cfg_write(ADDR_SIDE_THR, 255);
    cfg_write(ADDR_ENTER_CUT, 32767);
    cfg_write(ADDR_ERROR_GAIN, 0);
    cfg_write(ADDR_CENTER_WT, 0);
    cfg_write(ADDR_RING_MODE, 1);
    for (int i = 0; i < 200; i++) send(rand_req());
    drain();
    send_idle = 0; recv_idle = 0;
    cfg_write(ADDR_CENTER_THR, 255);
    cfg_write(ADDR_SIDE_THR, 0);
    cfg_write(ADDR_ENTER_CUT, 0);
    cfg_write(ADDR_ERROR_GAIN, 45);
    cfg_write(ADDR_CENTER_WT, 7);
    for (int i = 0; i < 30; i++) send(rand_req());
    drain();
    cfg_write(ADDR_CENTER_THR, 80);
    cfg_write(ADDR_SIDE_THR, 55);
    cfg_write(ADDR_ENTER_CUT, 2300);
    for (int i = 0; i < 150; i++) begin
      if (i % 50 == 0) ring_run(i % 100 == 0); else send(rand_req());
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
